// ===== rtl/message_tag_matcher_top_assert.svh =====
// assertion macros used by the message tag matcher checker
`ifndef MESSAGE_TAG_MATCHER_TOP_ASSERT_SVH
`define MESSAGE_TAG_MATCHER_TOP_ASSERT_SVH

// antecedent holds, consequent holds in the next cycle
`define MTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("message_tag_matcher: check failed");

// antecedent holds, consequent holds in the same cycle
`define MTM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("message_tag_matcher: check failed");

`endif

// ===== rtl/mtm_pkg.sv =====
// types, constants and match function shared by the message tag matcher
`timescale 1ns / 1ps

package mtm_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int SRC_W = 4;
    localparam int LEN_W = 24;
    localparam int TAG_W = 31;
    localparam int OFS_W = 32;

    localparam logic FUNC_POST   = 1'b0;
    localparam logic FUNC_HEADER = 1'b1;

    localparam logic [1:0] ST_MATCHED  = 2'd0;
    localparam logic [1:0] ST_QUEUED   = 2'd1;
    localparam logic [1:0] ST_PENDING  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic             func;
        logic [SRC_W-1:0] source;
        logic [LEN_W-1:0] length;
        logic [TAG_W-1:0] tag;
        logic             any_tag;
        logic [OFS_W-1:0] offset;
    } in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [SRC_W-1:0] match_source;
        logic [LEN_W-1:0] match_length;
        logic [TAG_W-1:0] match_tag;
        logic [OFS_W-1:0] match_offset;
    } out_t;

    typedef struct packed {
        logic [SRC_W-1:0] source;
        logic [LEN_W-1:0] length;
        logic [TAG_W-1:0] tag;
        logic [OFS_W-1:0] offset;
    } entry_t;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic   compare;
        logic   remove;
        logic   append;
        in_t    cmp_item;
        entry_t append_entry;
    } cell_ctl_t;

    typedef enum logic {
        S_IDLE,
        S_RESOLVE
    } state_t;

    function automatic logic fits(
        input logic [SRC_W-1:0] want_src,
        input logic [LEN_W-1:0] max_len,
        input logic [TAG_W-1:0] want_tag,
        input logic             any,
        input logic [SRC_W-1:0] src,
        input logic [LEN_W-1:0] len,
        input logic [TAG_W-1:0] tag
    );
        return (src == want_src) && (len <= max_len) && (any || (tag == want_tag));
    endfunction

endpackage

// ===== rtl/mtm_cell.sv =====
// one queue slot: holds an entry, compares it, shifts toward the head on removal
`timescale 1ns / 1ps

module mtm_cell
    import mtm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      prev_valid,
    input  logic      found_in,
    input  entry_t    sel_in,
    input  logic      next_valid,
    input  entry_t    next_entry,
    output logic      valid,
    output entry_t    entry,
    output logic      found_out,
    output entry_t    sel_out
);

    logic   valid_reg;
    logic   valid_next;
    logic   hit_reg;
    logic   hit_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   take;

    // oldest hit wins: a cell takes only if no older cell hit
    assign take      = hit_reg && !found_in;
    assign found_out = found_in || hit_reg;
    assign sel_out   = take ? (sel_in | entry_reg) : sel_in;
    assign valid     = valid_reg;
    assign entry     = entry_reg;

    always_comb
    begin
        hit_next   = hit_reg;
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctl.compare)
        begin
            hit_next = valid_reg && fits(ctl.cmp_item.source, ctl.cmp_item.length,
                                         ctl.cmp_item.tag, ctl.cmp_item.any_tag,
                                         entry_reg.source, entry_reg.length,
                                         entry_reg.tag);
        end
        if (ctl.remove && found_out)
        begin
            // the matched cell and all younger ones pull from the neighbor
            valid_next = next_valid;
            entry_next = next_entry;
        end
        else if (ctl.append && prev_valid && !valid_reg)
        begin
            valid_next = 1'b1;
            entry_next = ctl.append_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/message_tag_matcher_top.sv =====
// message tag matcher: unexpected queue as a chain of cells plus one pending receive
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------
//  in      | in        | in_valid/in_stall | in_data  (post or header)
//  out     | out       | out_valid/out_stall| out_data (status, matched msg)
//
//  each transaction: the accept edge latches the item and the per-cell compare,
//  and the edge that ends the resolve step picks the oldest hit through the cell
//  chain and loads the result register; no new item is taken until the resolve step ends
//  a stalled result holds the block in the resolve step until it is taken
//  reset clears the cell valid bits, the pending receive and the result valid
`timescale 1ns / 1ps

module message_tag_matcher_top
    import mtm_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    state_t    state_reg;
    state_t    state_next;
    logic      accept;
    logic      go;

    in_t       item_reg;
    logic      pend_hit_reg;
    logic      pend_valid_reg;
    logic      pend_valid_next;
    in_t       pend_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_t      out_reg;
    out_t      out_next;

    cell_ctl_t ctl;

    // neighbor links of the cell chain
    logic      valid_w [QUEUE_DEPTH];
    entry_t    entry_w [QUEUE_DEPTH];
    logic      found_w [QUEUE_DEPTH+1];
    entry_t    sel_w   [QUEUE_DEPTH+1];

    logic      found_any;
    logic      full;
    logic      is_post;

    assign accept    = in_valid && !in_stall;
    assign found_any = found_w[QUEUE_DEPTH];
    assign full      = valid_w[QUEUE_DEPTH-1];
    assign is_post   = (item_reg.func == FUNC_POST);
    assign found_w[0] = 1'b0;
    assign sel_w[0]   = '0;

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_stall = 1'b1;
        go       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_RESOLVE:
            begin
                // result register must be free or emptying this cycle
                go = !(out_valid_reg && out_stall);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // broadcast control to the cells
    always_comb
    begin
        ctl.compare      = accept;
        ctl.remove       = go && is_post && found_any;
        ctl.append       = go && !is_post && !pend_hit_reg && !full;
        ctl.cmp_item     = in_data;
        ctl.append_entry = '{source: item_reg.source, length: item_reg.length,
                             tag: item_reg.tag, offset: item_reg.offset};
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic   prev_v;
            logic   nxt_v;
            entry_t nxt_e;

            if (gi == 0)
            begin : g_head
                assign prev_v = 1'b1;
            end
            else
            begin : g_body
                assign prev_v = valid_w[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign nxt_v = 1'b0;
                assign nxt_e = '0;
            end
            else
            begin : g_link
                assign nxt_v = valid_w[gi+1];
                assign nxt_e = entry_w[gi+1];
            end

            mtm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .prev_valid (prev_v),
                .found_in   (found_w[gi]),
                .sel_in     (sel_w[gi]),
                .next_valid (nxt_v),
                .next_entry (nxt_e),
                .valid      (valid_w[gi]),
                .entry      (entry_w[gi]),
                .found_out  (found_w[gi+1]),
                .sel_out    (sel_w[gi+1])
            );
        end
    endgenerate

    // resolve step: pick the result and update the pending receive
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (go)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (is_post)
            begin
                if (found_any)
                begin
                    // a matched post leaves nothing pending
                    pend_valid_next       = 1'b0;
                    out_next.status       = ST_MATCHED;
                    out_next.match_source = sel_w[QUEUE_DEPTH].source;
                    out_next.match_length = sel_w[QUEUE_DEPTH].length;
                    out_next.match_tag    = sel_w[QUEUE_DEPTH].tag;
                    out_next.match_offset = sel_w[QUEUE_DEPTH].offset;
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    out_next.status = ST_PENDING;
                end
            end
            else if (pend_hit_reg)
            begin
                pend_valid_next       = 1'b0;
                out_next.status       = ST_MATCHED;
                out_next.match_source = item_reg.source;
                out_next.match_length = item_reg.length;
                out_next.match_tag    = item_reg.tag;
                out_next.match_offset = item_reg.offset;
            end
            else if (full)
            begin
                // header dropped, queue and pending receive untouched
                out_next.status = ST_OVERFLOW;
            end
            else
            begin
                out_next.status = ST_QUEUED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (go && is_post && !found_any)
            begin
                pend_reg <= item_reg;
            end
        end
    end

    // item and pending compare are latched at the accept edge
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept)
        begin
            item_reg     <= in_data;
            pend_hit_reg <= pend_valid_reg
                            && fits(pend_reg.source, pend_reg.length, pend_reg.tag,
                                    pend_reg.any_tag, in_data.source, in_data.length,
                                    in_data.tag);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/mtm_checker.sv =====
// port-level checks for the message tag matcher, bound to the top level
`timescale 1ns / 1ps
`include "message_tag_matcher_top_assert.svh"

module mtm_checker
    import mtm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input in_t  in_data,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    logic in_take;
    logic out_held;
    logic no_match_status;
    logic match_fields_zero;

    assign in_take           = in_valid && !in_stall;
    assign out_held          = out_valid && out_stall;
    assign no_match_status   = out_valid && (out_data.status != ST_MATCHED);
    assign match_fields_zero = (out_data.match_source == '0) && (out_data.match_length == '0)
                               && (out_data.match_tag == '0) && (out_data.match_offset == '0);

    `MTM_ASSERT_NEXT(a_out_hold_valid, out_held, out_valid)
    `MTM_ASSERT_NEXT(a_out_hold_data, out_held, $stable(out_data))
    `MTM_ASSERT_NEXT(a_busy_after_take, in_take, in_stall)
    `MTM_ASSERT_NOW(a_nomatch_zero, no_match_status, match_fields_zero)

endmodule

bind message_tag_matcher_top mtm_checker u_mtm_checker (.*);
